### rtl/core/saidx_pkg.sv
package saidx_pkg;

  localparam int HANDLE_W    = 6;
  localparam int NUM_HANDLES = 64;
  localparam int FIELD_W     = 32;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_MOVE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_GET   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_ADDY,
    S_PRD,
    S_MVX,
    S_MVY,
    S_AXIS,
    S_REM_RD,
    S_REM_CMP,
    S_INS_RD,
    S_INS_CMP,
    S_COMMIT,
    S_RESP,
    S_Q_RD,
    S_Q_PM,
    S_Q_CHK,
    S_Q_END
  } state_t;

endpackage

### rtl/core/saidx_alu.sv
module saidx_alu import saidx_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int SUM_W      = 33
) (
  input  logic signed [SUM_W-1:0]      a,
  input  logic signed [SUM_W-1:0]      b,
  output logic signed [COORD_BITS-1:0] sum_sat,
  output logic                         lt
);

  localparam logic signed [SUM_W:0] HI =
    {{(SUM_W-COORD_BITS+2){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W:0] LO = ~HI;

  logic signed [SUM_W:0] sum;

  assign sum = {a[SUM_W-1], a} + {b[SUM_W-1], b};
  assign lt  = a < b;

  always_comb begin
    if (sum > HI) begin
      sum_sat = HI[COORD_BITS-1:0];
    end else if (sum < LO) begin
      sum_sat = LO[COORD_BITS-1:0];
    end else begin
      sum_sat = sum[COORD_BITS-1:0];
    end
  end

endmodule

### rtl/core/sorted_axis_spatial_index.sv
// get reads only the position memory; add, move and query walk the sorted lists entry by entry,
// and a query also waits on output stalls
// throughput: one request at a time, set by the walk over the single-read-port list memories
// reset: sequencer, entity count, present bits, output valid and pending-hit flag clear at once;
// list and position memories are left unset and need no clearing pass
module sorted_axis_spatial_index import saidx_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [FIELD_W-1:0]  in_x_value,
  input  logic [FIELD_W-1:0]  in_y_value,
  input  logic [FIELD_W-1:0]  in_x_high,
  input  logic [FIELD_W-1:0]  in_y_high,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [FIELD_W-1:0]  out_x_pos,
  output logic [FIELD_W-1:0]  out_y_pos,
  output logic                out_hit,
  output logic [1:0]          out_status,
  output logic                out_last
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int SUM_W = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 1;
  localparam int C     = COORD_BITS;
  localparam int EW    = HANDLE_W + C;

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [FIELD_W-1:0]  xv_r, xv_nxt, yv_r, yv_nxt, xh_r, xh_nxt, yh_r, yh_nxt;
  logic                axis_r, axis_nxt;
  logic [CW-1:0]       k_r, k_nxt, cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic [C-1:0]        resx_r, resx_nxt, resy_r, resy_nxt;
  status_t             st_r, st_nxt;
  logic [NUM_HANDLES-1:0] present_r, present_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [HANDLE_W-1:0] pend_handle_r, pend_handle_nxt;
  logic [C-1:0]        pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [C-1:0]        out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                out_hit_r, out_hit_nxt, out_last_r, out_last_nxt;
  status_t             out_status_r, out_status_nxt;

  // sorted lists and per-handle positions
  logic [EW-1:0]  xlist_mem [CAPACITY];
  logic [EW-1:0]  ylist_mem [CAPACITY];
  logic [2*C-1:0] pos_mem [NUM_HANDLES];
  logic [EW-1:0]  xrd_r, yrd_r;
  logic [2*C-1:0] pm_rd_r;

  logic                lst_we, lst_wsel, lst_re;
  logic [AW-1:0]       lst_waddr, lst_raddr;
  logic [EW-1:0]       lst_wdata;
  logic                pm_we, pm_re;
  logic [HANDLE_W-1:0] pm_raddr;

  logic signed [SUM_W-1:0] alu_a, alu_b;
  logic signed [C-1:0]     alu_sum;
  logic                    alu_lt;

  logic [EW-1:0]       ent, new_ent;
  logic [HANDLE_W-1:0] ent_h;
  logic [C-1:0]        ent_p, ins_v, oldx, oldy, pmx, pmy;
  logic [CW-1:0]       km1;
  logic                full, changed, last_rem, q_hit, out_free;
  logic signed [SUM_W-1:0] qx, qy, bxl, bxh, byl, byh;

  saidx_alu #(.COORD_BITS(C), .SUM_W(SUM_W)) u_alu (
    .a(alu_a), .b(alu_b), .sum_sat(alu_sum), .lt(alu_lt)
  );

  always_ff @(posedge clk) begin
    if (lst_we && !lst_wsel) begin
      xlist_mem[lst_waddr] <= lst_wdata;
    end
    if (lst_we && lst_wsel) begin
      ylist_mem[lst_waddr] <= lst_wdata;
    end
    if (lst_re) begin
      xrd_r <= xlist_mem[lst_raddr];
      yrd_r <= ylist_mem[lst_raddr];
    end
    if (pm_we) begin
      pos_mem[handle_r] <= {resx_r, resy_r};
    end
    if (pm_re) begin
      pm_rd_r <= pos_mem[pm_raddr];
    end
  end

  assign ent      = axis_r ? yrd_r : xrd_r;
  assign ent_h    = ent[EW-1 -: HANDLE_W];
  assign ent_p    = ent[C-1:0];
  assign ins_v    = axis_r ? resy_r : resx_r;
  assign new_ent  = {handle_r, ins_v};
  assign km1      = k_r - 1'b1;
  assign full     = cnt_r >= CW'(CAPACITY);
  assign oldx     = pm_rd_r[2*C-1:C];
  assign oldy     = pm_rd_r[C-1:0];
  assign pmx      = oldx;
  assign pmy      = oldy;
  assign changed  = axis_r ? (resy_r != oldy) : (resx_r != oldx);
  assign last_rem = k_r == (cnt_r - 1'b1);
  assign out_free = !out_valid_r || out_ready;

  assign qx  = {{(SUM_W-C){pmx[C-1]}}, pmx};
  assign qy  = {{(SUM_W-C){pmy[C-1]}}, pmy};
  assign bxl = {{(SUM_W-FIELD_W){xv_r[FIELD_W-1]}}, xv_r};
  assign bxh = {{(SUM_W-FIELD_W){xh_r[FIELD_W-1]}}, xh_r};
  assign byl = {{(SUM_W-FIELD_W){yv_r[FIELD_W-1]}}, yv_r};
  assign byh = {{(SUM_W-FIELD_W){yh_r[FIELD_W-1]}}, yh_r};
  assign q_hit = (qy >= byl) && (qy < byh) && (qx > bxl) && (qx < bxh);

  // shared unit operand select
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_CHK:     alu_a = bxl;
      S_ADDY:    alu_a = byl;
      S_MVX: begin
        alu_a = {{(SUM_W-C){oldx[C-1]}}, oldx};
        alu_b = bxl;
      end
      S_MVY: begin
        alu_a = {{(SUM_W-C){oldy[C-1]}}, oldy};
        alu_b = byl;
      end
      S_INS_CMP: begin
        alu_a = {{(SUM_W-C){ent_p[C-1]}}, ent_p};
        alu_b = {{(SUM_W-C){ins_v[C-1]}}, ins_v};
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_t ins_done;
    if (axis_r) begin
      ins_done = S_COMMIT;
    end else if (req_r == REQ_ADD) begin
      ins_done = S_INS_RD;
    end else begin
      ins_done = S_AXIS;
    end
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (req_t'(in_req_type) == REQ_QUERY) ? S_Q_RD : S_CHK;
        end
      end
      S_CHK: begin
        if (req_r == REQ_ADD) begin
          state_nxt = (present_r[handle_r] || full) ? S_RESP : S_ADDY;
        end else begin
          state_nxt = present_r[handle_r] ? S_PRD : S_RESP;
        end
      end
      S_ADDY:    state_nxt = S_INS_RD;
      S_PRD:     state_nxt = (req_r == REQ_GET) ? S_RESP : S_MVX;
      S_MVX:     state_nxt = S_MVY;
      S_MVY:     state_nxt = S_AXIS;
      S_AXIS: begin
        if (changed) begin
          state_nxt = S_REM_RD;
        end else if (axis_r) begin
          state_nxt = S_COMMIT;
        end
      end
      S_REM_RD:  state_nxt = S_REM_CMP;
      S_REM_CMP: state_nxt = last_rem ? S_INS_RD : S_REM_RD;
      S_INS_RD:  state_nxt = (k_r == '0) ? ins_done : S_INS_CMP;
      S_INS_CMP: state_nxt = alu_lt ? ins_done : S_INS_RD;
      S_COMMIT:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_RD:    state_nxt = (k_r == '0) ? S_Q_END : S_Q_PM;
      S_Q_PM:    state_nxt = S_Q_CHK;
      S_Q_CHK: begin
        if (!(q_hit && pend_valid_r && !out_free)) begin
          state_nxt = S_Q_RD;
        end
      end
      S_Q_END: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt         = req_r;
    handle_nxt      = handle_r;
    xv_nxt          = xv_r;
    yv_nxt          = yv_r;
    xh_nxt          = xh_r;
    yh_nxt          = yh_r;
    axis_nxt        = axis_r;
    k_nxt           = k_r;
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    resx_nxt        = resx_r;
    resy_nxt        = resy_r;
    st_nxt          = st_r;
    present_nxt     = present_r;
    pend_valid_nxt  = pend_valid_r;
    pend_handle_nxt = pend_handle_r;
    pend_x_nxt      = pend_x_r;
    pend_y_nxt      = pend_y_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_handle_nxt  = out_handle_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_hit_nxt     = out_hit_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    lst_we          = 1'b0;
    lst_wsel        = axis_r;
    lst_waddr       = k_r[AW-1:0];
    lst_wdata       = new_ent;
    lst_re          = 1'b0;
    lst_raddr       = km1[AW-1:0];
    pm_we           = 1'b0;
    pm_re           = 1'b0;
    pm_raddr        = handle_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = req_t'(in_req_type);
          handle_nxt     = in_handle;
          xv_nxt         = in_x_value;
          yv_nxt         = in_y_value;
          xh_nxt         = in_x_high;
          yh_nxt         = in_y_high;
          axis_nxt       = 1'b0;
          k_nxt          = cnt_r;
          pend_valid_nxt = 1'b0;
        end
      end
      S_CHK: begin
        resx_nxt = '0;
        resy_nxt = '0;
        st_nxt   = ST_OK;
        pm_re    = 1'b1;
        if (req_r == REQ_ADD) begin
          if (present_r[handle_r]) begin
            st_nxt = ST_PRESENT;
          end else if (full) begin
            st_nxt = ST_FULL;
          end else begin
            resx_nxt = alu_sum;
          end
        end else if (!present_r[handle_r]) begin
          st_nxt = ST_UNKNOWN;
        end
      end
      S_ADDY: begin
        resy_nxt = alu_sum;
        k_nxt    = cnt_r;
      end
      S_PRD: begin
        if (req_r == REQ_GET) begin
          resx_nxt = oldx;
          resy_nxt = oldy;
        end
      end
      S_MVX: resx_nxt = alu_sum;
      S_MVY: begin
        resy_nxt = alu_sum;
        axis_nxt = 1'b0;
      end
      S_AXIS: begin
        if (changed) begin
          k_nxt     = '0;
          found_nxt = 1'b0;
        end else begin
          axis_nxt = 1'b1;
        end
      end
      S_REM_RD: begin
        lst_re    = 1'b1;
        lst_raddr = k_r[AW-1:0];
      end
      S_REM_CMP: begin
        // close the gap left by the moved entity
        if (found_r) begin
          lst_we    = 1'b1;
          lst_waddr = km1[AW-1:0];
          lst_wdata = ent;
        end
        if (ent_h == handle_r) begin
          found_nxt = 1'b1;
        end
        // insertion walks down from the end of the shortened list
        k_nxt = last_rem ? k_r : k_r + 1'b1;
      end
      S_INS_RD: begin
        if (k_r == '0) begin
          lst_we = 1'b1;
          if (!axis_r) begin
            axis_nxt = 1'b1;
            k_nxt    = cnt_r;
          end
        end else begin
          lst_re = 1'b1;
        end
      end
      S_INS_CMP: begin
        lst_we = 1'b1;
        if (!alu_lt) begin
          lst_wdata = ent;
          k_nxt     = km1;
        end else if (!axis_r) begin
          axis_nxt = 1'b1;
          k_nxt    = cnt_r;
        end
      end
      S_COMMIT: begin
        pm_we = 1'b1;
        if (req_r == REQ_ADD) begin
          cnt_nxt               = cnt_r + 1'b1;
          present_nxt[handle_r] = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = handle_r;
          out_x_nxt      = resx_r;
          out_y_nxt      = resy_r;
          out_hit_nxt    = st_r == ST_OK;
          out_status_nxt = st_r;
          out_last_nxt   = 1'b1;
        end
      end
      S_Q_RD: begin
        if (k_r != '0) begin
          lst_re = 1'b1;
        end
      end
      S_Q_PM: begin
        pm_re    = 1'b1;
        pm_raddr = yrd_r[EW-1 -: HANDLE_W];
      end
      S_Q_CHK: begin
        // hold one hit back so the final one can carry last
        if (!(q_hit && pend_valid_r && !out_free)) begin
          k_nxt = km1;
          if (q_hit) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_handle_nxt = pend_handle_r;
              out_x_nxt      = pend_x_r;
              out_y_nxt      = pend_y_r;
              out_hit_nxt    = 1'b1;
              out_status_nxt = ST_OK;
              out_last_nxt   = 1'b0;
            end
            pend_valid_nxt  = 1'b1;
            pend_handle_nxt = yrd_r[EW-1 -: HANDLE_W];
            pend_x_nxt      = pmx;
            pend_y_nxt      = pmy;
          end
        end
      end
      S_Q_END: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = pend_valid_r ? pend_handle_r : '0;
          out_x_nxt      = pend_valid_r ? pend_x_r : '0;
          out_y_nxt      = pend_valid_r ? pend_y_r : '0;
          out_hit_nxt    = pend_valid_r;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      present_r    <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      present_r    <= present_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    handle_r      <= handle_nxt;
    xv_r          <= xv_nxt;
    yv_r          <= yv_nxt;
    xh_r          <= xh_nxt;
    yh_r          <= yh_nxt;
    axis_r        <= axis_nxt;
    k_r           <= k_nxt;
    found_r       <= found_nxt;
    resx_r        <= resx_nxt;
    resy_r        <= resy_nxt;
    st_r          <= st_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_x_r      <= pend_x_nxt;
    pend_y_r      <= pend_y_nxt;
    out_handle_r  <= out_handle_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_hit_r     <= out_hit_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  logic signed [SUM_W-1:0] ox_ext, oy_ext;
  assign ox_ext = {{(SUM_W-C){out_x_r[C-1]}}, out_x_r};
  assign oy_ext = {{(SUM_W-C){out_y_r[C-1]}}, out_y_r};

  assign in_ready       = state_r == S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_x_pos      = ox_ext[FIELD_W-1:0];
  assign out_y_pos      = oy_ext[FIELD_W-1:0];
  assign out_hit        = out_hit_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entity count above capacity");

  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(cnt_r))
    else $error("present bits disagree with entity count");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("request accepted but sequencer idle");

  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_last)
    else $error("result without hit not marked last");
`endif

endmodule

### bench/sorted_axis_spatial_index_tb.sv
`timescale 1ns / 100ps

module sorted_axis_spatial_index_tb;
  import saidx_pkg::*;

  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [5:0]         handle;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               hit;
    status_t            status;
    logic               last;
  } answer_t;

  typedef struct packed {
    req_t               req;
    logic [5:0]         handle;
    logic signed [31:0] xv;
    logic signed [31:0] yv;
    logic signed [31:0] xh;
    logic signed [31:0] yh;
    logic               typed;
    answer_t            ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [5:0]  in_handle = '0;
  logic [31:0] in_x_value = '0;
  logic [31:0] in_y_value = '0;
  logic [31:0] in_x_high = '0;
  logic [31:0] in_y_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_handle_out;
  logic [31:0] out_x_pos;
  logic [31:0] out_y_pos;
  logic        out_hit;
  logic [1:0]  out_status;
  logic        out_last;

  sorted_axis_spatial_index i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_handle(in_handle),
    .in_x_value(in_x_value), .in_y_value(in_y_value),
    .in_x_high(in_x_high), .in_y_high(in_y_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_handle_out(out_handle_out), .out_x_pos(out_x_pos), .out_y_pos(out_y_pos),
    .out_hit(out_hit), .out_status(out_status), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // shadow copy of the two sorted lists and the handle map
  logic signed [31:0] axis_val[2][64];
  logic [5:0]         axis_owner[2][64];
  int                 slot_at[2][64];
  bit                 in_table[64];
  int                 n_stored;

  answer_t pending_answers[$];
  bit      failed;
  bit      quiet;
  int      idle_cycles;
  int      out_stall;
  row_t    rows[21];

  function automatic logic signed [31:0] clamp_coord(logic signed [32:0] v);
    if (v > 33'sd2147483647) return C_MAX;
    if (v < -33'sd2147483648) return C_MIN;
    return v[31:0];
  endfunction

  function automatic int first_not_below(int a, logic signed [31:0] v, int n);
    int i;
    i = 0;
    while (i < n && axis_val[a][i] < v) i++;
    return i;
  endfunction

  function automatic void place(int a, int i, logic [5:0] h, logic signed [31:0] v, int n);
    for (int k = n; k > i; k--) begin
      axis_val[a][k] = axis_val[a][k-1];
      axis_owner[a][k] = axis_owner[a][k-1];
      slot_at[a][axis_owner[a][k]] = k;
    end
    axis_val[a][i] = v;
    axis_owner[a][i] = h;
    slot_at[a][h] = i;
  endfunction

  function automatic void take_out(int a, int i, int n);
    for (int k = i; k + 1 < n; k++) begin
      axis_val[a][k] = axis_val[a][k+1];
      axis_owner[a][k] = axis_owner[a][k+1];
      slot_at[a][axis_owner[a][k]] = k;
    end
  endfunction

  function automatic answer_t mk(logic [5:0] h, logic signed [31:0] x, logic signed [31:0] y,
                                 logic hit, status_t st, logic last);
    answer_t r;
    r.handle = h; r.x = x; r.y = y; r.hit = hit; r.status = st; r.last = last;
    return r;
  endfunction

  function automatic void queue_answer(answer_t a);
    pending_answers = {pending_answers, a};
  endfunction

  // applies one request to the shadow tables and queues the answers it should produce
  function automatic void apply_request(req_t req, logic [5:0] h, logic signed [31:0] xv,
                                        logic signed [31:0] yv, logic signed [31:0] xh,
                                        logic signed [31:0] yh, bit record);
    logic signed [31:0] nv[2];
    logic signed [31:0] old;
    logic signed [31:0] delta;
    logic [5:0]         found[$];
    logic [5:0]         e;
    int                 i;
    case (req)
      REQ_ADD: begin
        if (in_table[h]) begin
          if (record) queue_answer(mk(h, 0, 0, 0, ST_PRESENT, 1));
        end else if (n_stored >= 64) begin
          if (record) queue_answer(mk(h, 0, 0, 0, ST_FULL, 1));
        end else begin
          nv[0] = xv; nv[1] = yv;
          for (int a = 0; a < 2; a++)
            place(a, first_not_below(a, nv[a], n_stored), h, nv[a], n_stored);
          n_stored++;
          in_table[h] = 1'b1;
          if (record) queue_answer(mk(h, nv[0], nv[1], 1, ST_OK, 1));
        end
      end
      REQ_MOVE: begin
        if (!in_table[h]) begin
          if (record) queue_answer(mk(h, 0, 0, 0, ST_UNKNOWN, 1));
        end else begin
          for (int a = 0; a < 2; a++) begin
            old = axis_val[a][slot_at[a][h]];
            delta = (a == 0) ? xv : yv;
            nv[a] = clamp_coord(33'(old) + 33'(delta));
            if (nv[a] != old) begin
              take_out(a, slot_at[a][h], n_stored);
              place(a, first_not_below(a, nv[a], n_stored - 1), h, nv[a], n_stored - 1);
            end
          end
          if (record) queue_answer(mk(h, nv[0], nv[1], 1, ST_OK, 1));
        end
      end
      REQ_GET: begin
        if (!in_table[h]) begin
          if (record) queue_answer(mk(h, 0, 0, 0, ST_UNKNOWN, 1));
        end else if (record) begin
          queue_answer(mk(h, axis_val[0][slot_at[0][h]],
                          axis_val[1][slot_at[1][h]], 1, ST_OK, 1));
        end
      end
      default: begin
        i = first_not_below(1, yv, n_stored);
        while (i < n_stored && axis_val[1][i] < yh) begin
          e = axis_owner[1][i];
          if (axis_val[0][slot_at[0][e]] > xv && axis_val[0][slot_at[0][e]] < xh)
            found = {found, e};
          i++;
        end
        if (!record) return;
        if (found.size() == 0) queue_answer(mk(0, 0, 0, 0, ST_OK, 1));
        // reported top-down in y
        for (int k = found.size() - 1; k >= 0; k--)
          queue_answer(mk(found[k], axis_val[0][slot_at[0][found[k]]],
                          axis_val[1][slot_at[1][found[k]]], 1, ST_OK, k == 0));
      end
    endcase
  endfunction

  task automatic send_request(row_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req;
    in_handle <= r.handle;
    in_x_value <= r.xv;
    in_y_value <= r.yv;
    in_x_high <= r.xh;
    in_y_high <= r.yh;
    do @(posedge clk); while (!in_ready);
    apply_request(r.req, r.handle, r.xv, r.yv, r.xh, r.yh, !r.typed);
    if (r.typed) queue_answer(r.ans);
  endtask

  function automatic logic signed [31:0] pick_coord();
    if ($urandom_range(0, 9) < 8) return $signed($urandom_range(0, 40)) - 20;
    return $urandom;
  endfunction

  // result side: random stall drawn per result
  always @(posedge clk) begin
    answer_t want;
    int      nxt;
    if (out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result handle %0d", $time, out_handle_out);
        failed = 1'b1;
      end else begin
        want = pending_answers.pop_front();
        if (out_handle_out !== want.handle) begin
          $display("%0t: handle expected %0d actual %0d", $time, want.handle, out_handle_out);
          failed = 1'b1;
        end
        if (out_x_pos !== want.x) begin
          $display("%0t: x_pos expected %0d actual %0d", $time, want.x, $signed(out_x_pos));
          failed = 1'b1;
        end
        if (out_y_pos !== want.y) begin
          $display("%0t: y_pos expected %0d actual %0d", $time, want.y, $signed(out_y_pos));
          failed = 1'b1;
        end
        if (out_hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
          failed = 1'b1;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          failed = 1'b1;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          failed = 1'b1;
        end
      end
      nxt = quiet ? 0 : $urandom_range(0, 13);
      out_stall <= nxt;
      out_ready <= (nxt == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= rst_n;
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t r;
    int   pick;
    failed = 1'b0;
    quiet = 1'b0;
    idle_cycles = 0;
    out_stall = 0;
    n_stored = 0;
    foreach (in_table[h]) in_table[h] = 1'b0;

    rows[0]  = '{REQ_QUERY, 6'd0, 0, 0, 0, 0, 1'b1, mk(0, 0, 0, 0, ST_OK, 1)};
    rows[1]  = '{REQ_GET, 6'd5, 0, 0, 0, 0, 1'b1, mk(5, 0, 0, 0, ST_UNKNOWN, 1)};
    rows[2]  = '{REQ_MOVE, 6'd5, 1, 1, 0, 0, 1'b1, mk(5, 0, 0, 0, ST_UNKNOWN, 1)};
    rows[3]  = '{REQ_ADD, 6'd0, C_MIN, C_MAX, 0, 0, 1'b1, mk(0, C_MIN, C_MAX, 1, ST_OK, 1)};
    rows[4]  = '{REQ_ADD, 6'd0, 7, 7, 0, 0, 1'b1, mk(0, 0, 0, 0, ST_PRESENT, 1)};
    rows[5]  = '{REQ_ADD, 6'd63, C_MAX, C_MIN, -1, -1, 1'b1, mk(63, C_MAX, C_MIN, 1, ST_OK, 1)};
    rows[6]  = '{REQ_ADD, 6'd1, 0, 0, 0, 0, 1'b0, '0};
    rows[7]  = '{REQ_ADD, 6'd2, 0, 0, 0, 0, 1'b0, '0};
    rows[8]  = '{REQ_ADD, 6'd3, 5, -5, 0, 0, 1'b0, '0};
    rows[9]  = '{REQ_MOVE, 6'd1, 0, 0, 0, 0, 1'b0, '0};
    rows[10] = '{REQ_MOVE, 6'd0, -1, 1, 0, 0, 1'b1, mk(0, C_MIN, C_MAX, 1, ST_OK, 1)};
    rows[11] = '{REQ_MOVE, 6'd63, C_MAX, C_MIN, 0, 0, 1'b0, '0};
    rows[12] = '{REQ_MOVE, 6'd2, 3, 0, 0, 0, 1'b0, '0};
    rows[13] = '{REQ_MOVE, 6'd3, -5, 5, 0, 0, 1'b0, '0};
    rows[14] = '{REQ_GET, 6'd3, 0, 0, 0, 0, 1'b0, '0};
    rows[15] = '{REQ_GET, 6'd63, 0, 0, 0, 0, 1'b0, '0};
    rows[16] = '{REQ_QUERY, 6'd0, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, '0};
    rows[17] = '{REQ_QUERY, 6'd0, 10, 10, -10, -10, 1'b1, mk(0, 0, 0, 0, ST_OK, 1)};
    rows[18] = '{REQ_QUERY, 6'd0, -10, -10, 10, 10, 1'b0, '0};
    rows[19] = '{REQ_MOVE, 6'd2, C_MIN, C_MIN, 0, 0, 1'b0, '0};
    rows[20] = '{REQ_QUERY, 6'd0, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, '0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i]);

    for (int n = 0; n < 140; n++) begin
      quiet = (n >= 60 && n < 90);
      // hold off until the block has drained everything
      if (n == 100) begin
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      r = '0;
      r.handle = $urandom_range(0, 63);
      r.xv = pick_coord();
      r.yv = pick_coord();
      r.xh = pick_coord();
      r.yh = pick_coord();
      if (pick < 35) begin
        r.req = REQ_ADD;
      end else if (pick < 60) begin
        r.req = REQ_MOVE;
        if ($urandom_range(0, 7) == 0) r.xv = 0;
      end else if (pick < 80) begin
        r.req = REQ_QUERY;
        if ($urandom_range(0, 3) == 0) begin
          r.xv = r.xv - 20; r.yv = r.yv - 20; r.xh = r.xh + 20; r.yh = r.yh + 20;
        end
      end else begin
        r.req = REQ_GET;
      end
      send_request(r);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
